// ===== hw/rtl/crqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqs_pkg: shared types and codes of the CPU ready-queue scheduler
// Field widths, command and result codes, register indexes and the control
// bundles passed between the sequencer and its helper units.
// ----------------------------------------------------------------------------
package crqs_pkg;

	localparam int CMD_W   = 2;
	localparam int CPU_W   = 4;
	localparam int PID_W   = 8;
	localparam int PRIO_W  = 8;
	localparam int KIND_W  = 2;
	localparam int SLICE_W = 17;
	localparam int MODE_W  = 2;
	localparam int ACT_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int ENTRY_W = PRIO_W + PID_W;

	// input commands
	localparam logic [CMD_W-1:0] CMD_WAKE    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PREEMPT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_IDLE    = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_IDLE     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PREEMPT  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DROP     = 2'd3;

	// scheduling mode that enables the priority search and preemption
	localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd2;

	// control of the shared compare unit
	typedef struct packed {
		logic valid;
		logic first;
		logic find_min;
	} best_ctl_t;

	// control of the per-CPU slot store
	typedef struct packed {
		logic wr_en;
		logic busy_we;
		logic busy_val;
	} slot_op_t;

endpackage

// ===== hw/rtl/crqs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqs_queue: ready-queue entry store
// One write port and one registered read port over {priority, pid} entries.
// ----------------------------------------------------------------------------
module crqs_queue #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [crqs_pkg::ENTRY_W-1:0] wr_data,
	input  logic [AW-1:0]                rd_addr,
	output logic [crqs_pkg::ENTRY_W-1:0] rd_data
);

	logic [crqs_pkg::ENTRY_W-1:0] mem_q [DEPTH];
	logic [crqs_pkg::ENTRY_W-1:0] rd_data_q;

	// write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// register the read data
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/crqs_slots.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqs_slots: per-CPU current-process slots
// Holds the running {priority, pid} of each CPU in a small memory with a
// registered read port, and the busy flags in flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module crqs_slots #(
	parameter int NCPU = 16,
	parameter int AW   = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  crqs_pkg::slot_op_t           op,
	input  logic [AW-1:0]                wr_addr,
	input  logic [crqs_pkg::ENTRY_W-1:0] wr_data,
	input  logic [AW-1:0]                rd_addr,
	output logic [crqs_pkg::ENTRY_W-1:0] rd_data,
	output logic [NCPU-1:0]              busy
);

	logic [crqs_pkg::ENTRY_W-1:0] mem_q [NCPU];
	logic [crqs_pkg::ENTRY_W-1:0] rd_data_q;
	logic [NCPU-1:0]              busy_q;

	// write the running process of one CPU
	always_ff @(posedge clk) begin
		if (op.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// register the read data
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	// set or clear one busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (op.busy_we) begin
			busy_q[wr_addr] <= op.busy_val;
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

// ===== hw/rtl/crqs_best.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqs_best: shared priority compare unit
// Takes one key per cycle and keeps the first maximum or the first minimum
// seen since the start of a scan, with its index.
// ----------------------------------------------------------------------------
module crqs_best #(
	parameter int IW = 6
) (
	input  logic                        clk,
	input  crqs_pkg::best_ctl_t         ctl,
	input  logic [crqs_pkg::PRIO_W-1:0] key,
	input  logic [IW-1:0]               idx,
	output logic [crqs_pkg::PRIO_W-1:0] best_key,
	output logic [IW-1:0]               best_idx
);

	logic [crqs_pkg::PRIO_W-1:0] best_key_q;
	logic [IW-1:0]               best_idx_q;
	logic                        take;

	// strict compare keeps the earliest of equal keys
	always_comb begin
		if (ctl.first) begin
			take = 1'b1;
		end else if (ctl.find_min) begin
			take = key < best_key_q;
		end else begin
			take = key > best_key_q;
		end
	end

	// hold the running best
	always_ff @(posedge clk) begin
		if (ctl.valid && take) begin
			best_key_q <= key;
			best_idx_q <= idx;
		end
	end

	assign best_key = best_key_q;
	assign best_idx = best_idx_q;

endmodule

// ===== hw/rtl/cpu_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_ready_queue_scheduler: ready-queue dispatcher with priority preemption
// A sequencer drives the queue store, the CPU slot store and one shared
// compare unit that walks stored entries one per cycle.
// ----------------------------------------------------------------------------
// Steps to a result: a drop ends at decode or re-queue, an idle result at dispatch; a
// wake with preempt check adds a scan of the active CPUs; a dispatch adds the priority
// search in priority mode, a pick read and write, a shift of the later entries, and a
// re-queue for a preempt of a busy CPU. One item at a time; a plain wake frees the
// input after decode. A result still in the output register stalls the finish.
// Reset: queue empty, every CPU idle, registers at reset values; no clearing pass.
// ----------------------------------------------------------------------------
module cpu_ready_queue_scheduler #(
	parameter int QUEUE_DEPTH = 32,
	parameter int MAX_CPUS    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [crqs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crqs_pkg::SLICE_W-1:0]        cfg_data,
	// command channel
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  logic [crqs_pkg::CMD_W-1:0]          command,
	input  logic [crqs_pkg::CPU_W-1:0]          cpu,
	input  logic [crqs_pkg::PID_W-1:0]          pid,
	input  logic [crqs_pkg::PRIO_W-1:0]         priority_req,
	// result channel
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [crqs_pkg::KIND_W-1:0]         kind,
	output logic [crqs_pkg::CPU_W-1:0]          target_cpu,
	output logic [crqs_pkg::PID_W-1:0]          chosen_pid,
	output logic signed [crqs_pkg::SLICE_W-1:0] granted_slice
);

	localparam int QIW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int NW   = $clog2(MAX_CPUS + 1);
	localparam int SCW  = (CNTW > NW) ? CNTW : NW;
	localparam int LW   = (NW > crqs_pkg::ACT_W) ? NW : crqs_pkg::ACT_W;
	localparam logic [CNTW-1:0] FULL_C = CNTW'(QUEUE_DEPTH);

	// sequencer states
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECODE  = 3'd1;
	localparam logic [2:0] ST_REQUEUE = 3'd2;
	localparam logic [2:0] ST_DISP    = 3'd3;
	localparam logic [2:0] ST_SCAN    = 3'd4;
	localparam logic [2:0] ST_PICK_RD = 3'd5;
	localparam logic [2:0] ST_PICK_WR = 3'd6;
	localparam logic [2:0] ST_FIN     = 3'd7;

	// scan purposes
	localparam logic [1:0] SCAN_MAX   = 2'd0;
	localparam logic [1:0] SCAN_MIN   = 2'd1;
	localparam logic [1:0] SCAN_SHIFT = 2'd2;

	logic [2:0]                         state_q;
	logic [crqs_pkg::MODE_W-1:0]        mode_q;
	logic signed [crqs_pkg::SLICE_W-1:0] slice_q;
	logic [crqs_pkg::ACT_W-1:0]         active_q;

	logic [crqs_pkg::CMD_W-1:0]         cmd_q;
	logic [crqs_pkg::CPU_W-1:0]         cpu_q;
	logic [crqs_pkg::PID_W-1:0]         pid_q;
	logic [crqs_pkg::PRIO_W-1:0]        prio_q;
	logic [CNTW-1:0]                    count_q;
	logic [QIW-1:0]                     pick_q;

	logic [1:0]                         purpose_q;
	logic [SCW-1:0]                     scan_idx_q;
	logic [SCW-1:0]                     scan_lim_q;
	logic [SCW-1:0]                     pend_idx_q;
	logic                               pend_q;
	logic                               first_q;

	logic [crqs_pkg::KIND_W-1:0]        res_kind_q;
	logic [crqs_pkg::CPU_W-1:0]         res_cpu_q;
	logic [crqs_pkg::PID_W-1:0]         res_pid_q;
	logic signed [crqs_pkg::SLICE_W-1:0] res_slice_q;

	logic                               out_valid_q;
	logic [crqs_pkg::KIND_W-1:0]        out_kind_q;
	logic [crqs_pkg::CPU_W-1:0]         out_cpu_q;
	logic [crqs_pkg::PID_W-1:0]         out_pid_q;
	logic signed [crqs_pkg::SLICE_W-1:0] out_slice_q;

	logic [LW-1:0]                      lim_w;
	logic [NW-1:0]                      n_cpus;
	logic                               all_busy;
	logic [CW-1:0]                      cpu_idx;
	logic                               full;
	logic                               issue;
	logic                               scan_done;

	logic                               q_we;
	logic [QIW-1:0]                     q_waddr;
	logic [crqs_pkg::ENTRY_W-1:0]       q_wdata;
	logic [QIW-1:0]                     q_raddr;
	logic [crqs_pkg::ENTRY_W-1:0]       q_rd;

	crqs_pkg::slot_op_t                 s_op;
	logic [CW-1:0]                      s_raddr;
	logic [crqs_pkg::ENTRY_W-1:0]       s_rd;
	logic [MAX_CPUS-1:0]                busy;

	crqs_pkg::best_ctl_t                b_ctl;
	logic [crqs_pkg::PRIO_W-1:0]        b_key;
	logic [crqs_pkg::PRIO_W-1:0]        best_key;
	logic [SCW-1:0]                     best_idx;

	// clamp the active CPU count into 1 .. MAX_CPUS
	always_comb begin
		lim_w = LW'(active_q);
		if (active_q == '0) begin
			lim_w = LW'(1);
		end else if (lim_w > LW'(MAX_CPUS)) begin
			lim_w = LW'(MAX_CPUS);
		end
		n_cpus = NW'(lim_w);
	end

	// check whether every active CPU runs a process
	always_comb begin
		all_busy = 1'b1;
		for (int i = 0; i < MAX_CPUS; i++) begin
			if (i < int'(n_cpus) && !busy[i]) begin
				all_busy = 1'b0;
			end
		end
	end

	assign cpu_idx   = CW'(cpu_q);
	assign full      = (count_q == FULL_C);
	assign issue     = (scan_idx_q < scan_lim_q);
	assign scan_done = !issue && !pend_q;
	assign cmd_ready = (state_q == ST_IDLE);
	assign b_key     = (purpose_q == SCAN_MIN) ? s_rd[crqs_pkg::ENTRY_W-1:crqs_pkg::PID_W]
	                                           : q_rd[crqs_pkg::ENTRY_W-1:crqs_pkg::PID_W];

	// drive the stores and the compare unit
	always_comb begin
		q_we    = 1'b0;
		q_waddr = QIW'(count_q);
		q_wdata = {prio_q, pid_q};
		q_raddr = QIW'(scan_idx_q);
		s_op    = '0;
		s_raddr = cpu_idx;
		b_ctl   = '0;
		unique case (state_q)
			ST_DECODE: begin
				if (cmd_q == crqs_pkg::CMD_WAKE && !full) begin
					q_we = 1'b1;
				end
			end
			ST_REQUEUE: begin
				if (!full) begin
					q_we    = 1'b1;
					q_wdata = s_rd;
				end
			end
			ST_DISP: begin
				if (count_q == '0) begin
					s_op.busy_we  = 1'b1;
					s_op.busy_val = 1'b0;
				end
			end
			ST_SCAN: begin
				if (purpose_q == SCAN_MIN) begin
					s_raddr = CW'(scan_idx_q);
				end
				if (pend_q) begin
					if (purpose_q == SCAN_SHIFT) begin
						q_we    = 1'b1;
						q_waddr = QIW'(pend_idx_q - SCW'(1));
						q_wdata = q_rd;
					end else begin
						b_ctl.valid    = 1'b1;
						b_ctl.first    = first_q;
						b_ctl.find_min = (purpose_q == SCAN_MIN);
					end
				end
			end
			ST_PICK_RD: begin
				q_raddr = pick_q;
			end
			ST_PICK_WR: begin
				s_op.wr_en    = 1'b1;
				s_op.busy_we  = 1'b1;
				s_op.busy_val = 1'b1;
			end
			default: ;
		endcase
	end

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			slice_q  <= '1;
			active_q <= crqs_pkg::ACT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				crqs_pkg::REG_MODE:   mode_q   <= cfg_data[crqs_pkg::MODE_W-1:0];
				crqs_pkg::REG_SLICE:  slice_q  <= cfg_data;
				crqs_pkg::REG_ACTIVE: active_q <= cfg_data[crqs_pkg::ACT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequence one item through decode, scans, dispatch and shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cmd_q       <= '0;
			cpu_q       <= '0;
			pid_q       <= '0;
			prio_q      <= '0;
			pick_q      <= '0;
			purpose_q   <= SCAN_MAX;
			scan_idx_q  <= '0;
			scan_lim_q  <= '0;
			pend_idx_q  <= '0;
			res_kind_q  <= '0;
			res_cpu_q   <= '0;
			res_pid_q   <= '0;
			res_slice_q <= '0;
			out_kind_q  <= '0;
			out_cpu_q   <= '0;
			out_pid_q   <= '0;
			out_slice_q <= '0;
		end else begin
			// advance the scan read pipeline
			pend_q     <= (state_q == ST_SCAN) && issue;
			pend_idx_q <= scan_idx_q;
			if (state_q == ST_SCAN && issue) begin
				scan_idx_q <= scan_idx_q + SCW'(1);
			end
			if (state_q == ST_SCAN && pend_q) begin
				first_q <= 1'b0;
			end

			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && res_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= command;
						cpu_q   <= cpu;
						pid_q   <= pid;
						prio_q  <= priority_req;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (cmd_q == crqs_pkg::CMD_WAKE) begin
						if (full) begin
							res_kind_q  <= crqs_pkg::KIND_DROP;
							res_cpu_q   <= '0;
							res_pid_q   <= pid_q;
							res_slice_q <= '0;
							state_q     <= ST_FIN;
						end else begin
							count_q <= count_q + CNTW'(1);
							if (mode_q != crqs_pkg::MODE_PRIO || !all_busy) begin
								state_q <= ST_IDLE;
							end else begin
								purpose_q  <= SCAN_MIN;
								scan_idx_q <= '0;
								scan_lim_q <= SCW'(n_cpus);
								first_q    <= 1'b1;
								state_q    <= ST_SCAN;
							end
						end
					end else if (LW'(cpu_q) >= lim_w) begin
						state_q <= ST_IDLE;
					end else if (cmd_q == crqs_pkg::CMD_PREEMPT && busy[cpu_idx]) begin
						state_q <= ST_REQUEUE;
					end else begin
						state_q <= ST_DISP;
					end
				end
				ST_REQUEUE: begin
					if (full) begin
						res_kind_q  <= crqs_pkg::KIND_DROP;
						res_cpu_q   <= cpu_q;
						res_pid_q   <= s_rd[crqs_pkg::PID_W-1:0];
						res_slice_q <= '0;
						state_q     <= ST_FIN;
					end else begin
						count_q <= count_q + CNTW'(1);
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (count_q == '0) begin
						res_kind_q  <= crqs_pkg::KIND_IDLE;
						res_cpu_q   <= cpu_q;
						res_pid_q   <= '0;
						res_slice_q <= '0;
						state_q     <= ST_FIN;
					end else if (mode_q == crqs_pkg::MODE_PRIO) begin
						purpose_q  <= SCAN_MAX;
						scan_idx_q <= '0;
						scan_lim_q <= SCW'(count_q);
						first_q    <= 1'b1;
						state_q    <= ST_SCAN;
					end else begin
						pick_q  <= '0;
						state_q <= ST_PICK_RD;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						unique case (purpose_q)
							SCAN_MAX: begin
								pick_q  <= QIW'(best_idx);
								state_q <= ST_PICK_RD;
							end
							SCAN_MIN: begin
								if (best_key < prio_q) begin
									res_kind_q  <= crqs_pkg::KIND_PREEMPT;
									res_cpu_q   <= crqs_pkg::CPU_W'(best_idx);
									res_pid_q   <= '0;
									res_slice_q <= '0;
									state_q     <= ST_FIN;
								end else begin
									state_q <= ST_IDLE;
								end
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_PICK_RD: begin
					state_q <= ST_PICK_WR;
				end
				ST_PICK_WR: begin
					res_kind_q  <= crqs_pkg::KIND_DISPATCH;
					res_cpu_q   <= cpu_q;
					res_pid_q   <= q_rd[crqs_pkg::PID_W-1:0];
					res_slice_q <= slice_q;
					count_q     <= count_q - CNTW'(1);
					// close the gap left by the picked entry
					purpose_q   <= SCAN_SHIFT;
					scan_idx_q  <= SCW'(pick_q) + SCW'(1);
					scan_lim_q  <= SCW'(count_q);
					state_q     <= ST_SCAN;
				end
				ST_FIN: begin
					if (!out_valid_q || res_ready) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= res_kind_q;
						out_cpu_q   <= res_cpu_q;
						out_pid_q   <= res_pid_q;
						out_slice_q <= res_slice_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	crqs_queue #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (QIW)
	) u_queue (
		.clk     (clk),
		.wr_en   (q_we),
		.wr_addr (q_waddr),
		.wr_data (q_wdata),
		.rd_addr (q_raddr),
		.rd_data (q_rd)
	);

	crqs_slots #(
		.NCPU (MAX_CPUS),
		.AW   (CW)
	) u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (s_op),
		.wr_addr (cpu_idx),
		.wr_data (q_rd),
		.rd_addr (s_raddr),
		.rd_data (s_rd),
		.busy    (busy)
	);

	crqs_best #(
		.IW (SCW)
	) u_best (
		.clk      (clk),
		.ctl      (b_ctl),
		.key      (b_key),
		.idx      (pend_idx_q),
		.best_key (best_key),
		.best_idx (best_idx)
	);

	assign res_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign target_cpu    = out_cpu_q;
	assign chosen_pid    = out_pid_q;
	assign granted_slice = out_slice_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CPU ready-queue scheduler
// Drives wake, preempt, release and idle commands through the valid/ready
// command channel. A scheduler model inside the bench tracks the ready queue
// and the per-CPU slots and predicts each result. The results channel is
// compared in order, field by field. Several register settings are covered,
// including the unused mode and out-of-range CPU counts.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int QDEPTH        = 32;
	localparam int NCPU          = 16;
	localparam int SETTLE_CYCLES = 48;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 4000;
	localparam int IDLE_PCT      = 28;

	localparam logic [crqs_pkg::MODE_W-1:0]  MODE_FIFO  = 2'd0;
	localparam logic [crqs_pkg::MODE_W-1:0]  MODE_RR    = 2'd1;
	localparam logic [crqs_pkg::MODE_W-1:0]  MODE_SPARE = 2'd3;
	localparam logic [crqs_pkg::SLICE_W-1:0] SLICE_UNLIMITED = 17'h1FFFF;

	typedef struct packed {
		logic [crqs_pkg::CMD_W-1:0]  cmd;
		logic [crqs_pkg::CPU_W-1:0]  cpu;
		logic [crqs_pkg::PID_W-1:0]  pid;
		logic [crqs_pkg::PRIO_W-1:0] pri;
	} sched_cmd_t;

	typedef struct packed {
		logic [crqs_pkg::KIND_W-1:0]  kind;
		logic [crqs_pkg::CPU_W-1:0]   tcpu;
		logic [crqs_pkg::PID_W-1:0]   pid;
		logic [crqs_pkg::SLICE_W-1:0] slice;
	} sched_res_t;

	// clock, reset and block ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [crqs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [crqs_pkg::SLICE_W-1:0] cfg_data = '0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic [crqs_pkg::CMD_W-1:0] command = '0;
	logic [crqs_pkg::CPU_W-1:0] cpu = '0;
	logic [crqs_pkg::PID_W-1:0] pid = '0;
	logic [crqs_pkg::PRIO_W-1:0] priority_req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [crqs_pkg::KIND_W-1:0] kind;
	logic [crqs_pkg::CPU_W-1:0] target_cpu;
	logic [crqs_pkg::PID_W-1:0] chosen_pid;
	logic signed [crqs_pkg::SLICE_W-1:0] granted_slice;

	// scheduler model state and register copies
	logic [crqs_pkg::MODE_W-1:0]  sched_mode = MODE_FIFO;
	logic [crqs_pkg::SLICE_W-1:0] slice_len = SLICE_UNLIMITED;
	logic [crqs_pkg::ACT_W-1:0]   act_cpus = 5'd1;
	logic [crqs_pkg::PID_W-1:0]   rq_pid [QDEPTH];
	logic [crqs_pkg::PRIO_W-1:0]  rq_pri [QDEPTH];
	int                           rq_cnt = 0;
	logic [crqs_pkg::PID_W-1:0]   run_pid [NCPU];
	logic [crqs_pkg::PRIO_W-1:0]  run_pri [NCPU];
	logic                         cpu_busy [NCPU];

	// commands waiting to be sent and results waiting to arrive
	sched_cmd_t cmd_backlog [$];
	sched_res_t due_results [$];
	sched_res_t want;

	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;
	bit  calm = 1'b0;

	cpu_ready_queue_scheduler #(
		.QUEUE_DEPTH(QDEPTH),
		.MAX_CPUS(NCPU)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.cpu(cpu),
		.pid(pid),
		.priority_req(priority_req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.kind(kind),
		.target_cpu(target_cpu),
		.chosen_pid(chosen_pid),
		.granted_slice(granted_slice)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// CPU count in effect: zero acts as one, above the limit acts as the limit
	function automatic int eff_cpus();
		if (act_cpus == 0) return 1;
		if (int'(act_cpus) > NCPU) return NCPU;
		return int'(act_cpus);
	endfunction

	// advance the scheduler model by one command, queue its result if any
	function automatic void schedule_cmd(input sched_cmd_t c);
		sched_res_t r;
		int n;
		int i;
		int low;
		int pick;
		bit hit;
		bit busy_all;
		bit refused;
		r = '0;
		n = eff_cpus();
		hit = 1'b0;
		if (c.cmd == crqs_pkg::CMD_WAKE) begin
			if (rq_cnt >= QDEPTH) begin
				r.kind = crqs_pkg::KIND_DROP;
				r.pid = c.pid;
				hit = 1'b1;
			end else begin
				rq_pid[rq_cnt] = c.pid;
				rq_pri[rq_cnt] = c.pri;
				rq_cnt++;
				busy_all = 1'b1;
				for (i = 0; i < n; i++)
					if (!cpu_busy[i]) busy_all = 1'b0;
				// ask to preempt the lowest-priority CPU, first one on ties
				if (sched_mode == crqs_pkg::MODE_PRIO && busy_all) begin
					low = 0;
					for (i = 1; i < n; i++)
						if (run_pri[i] < run_pri[low]) low = i;
					if (run_pri[low] < c.pri) begin
						r.kind = crqs_pkg::KIND_PREEMPT;
						r.tcpu = crqs_pkg::CPU_W'(low);
						hit = 1'b1;
					end
				end
			end
		end else if (int'(c.cpu) < n) begin
			hit = 1'b1;
			refused = 1'b0;
			// requeue the running process, or refuse when the queue is full
			if (c.cmd == crqs_pkg::CMD_PREEMPT && cpu_busy[c.cpu]) begin
				if (rq_cnt >= QDEPTH) begin
					r.kind = crqs_pkg::KIND_DROP;
					r.tcpu = c.cpu;
					r.pid = run_pid[c.cpu];
					refused = 1'b1;
				end else begin
					rq_pid[rq_cnt] = run_pid[c.cpu];
					rq_pri[rq_cnt] = run_pri[c.cpu];
					rq_cnt++;
					cpu_busy[c.cpu] = 1'b0;
				end
			end
			if (!refused) begin
				if (rq_cnt == 0) begin
					cpu_busy[c.cpu] = 1'b0;
					r.kind = crqs_pkg::KIND_IDLE;
					r.tcpu = c.cpu;
				end else begin
					pick = 0;
					if (sched_mode == crqs_pkg::MODE_PRIO)
						for (i = 1; i < rq_cnt; i++)
							if (rq_pri[i] > rq_pri[pick]) pick = i;
					run_pid[c.cpu] = rq_pid[pick];
					run_pri[c.cpu] = rq_pri[pick];
					cpu_busy[c.cpu] = 1'b1;
					// close the gap, keep the order of the rest
					for (i = pick; i + 1 < rq_cnt; i++) begin
						rq_pid[i] = rq_pid[i + 1];
						rq_pri[i] = rq_pri[i + 1];
					end
					rq_cnt--;
					r.kind = crqs_pkg::KIND_DISPATCH;
					r.tcpu = c.cpu;
					r.pid = run_pid[c.cpu];
					r.slice = slice_len;
				end
			end
		end
		if (hit) due_results.push_back(r);
	endfunction

	function automatic void add_cmd(input logic [crqs_pkg::CMD_W-1:0] cmd, input int c,
			input int p, input int pr);
		sched_cmd_t x;
		x.cmd = cmd;
		x.cpu = crqs_pkg::CPU_W'(c);
		x.pid = crqs_pkg::PID_W'(p);
		x.pri = crqs_pkg::PRIO_W'(pr);
		cmd_backlog.push_back(x);
	endfunction

	// random command; the CPU is mostly one in use, sometimes any index
	function automatic sched_cmd_t rand_cmd(input int wake_pct, input int pri_max);
		sched_cmd_t x;
		if ($urandom_range(99) < wake_pct) begin
			x.cmd = crqs_pkg::CMD_WAKE;
		end else begin
			case ($urandom_range(2))
				0: x.cmd = crqs_pkg::CMD_PREEMPT;
				1: x.cmd = crqs_pkg::CMD_RELEASE;
				default: x.cmd = crqs_pkg::CMD_IDLE;
			endcase
		end
		if ($urandom_range(9) == 0)
			x.cpu = crqs_pkg::CPU_W'($urandom_range(15));
		else
			x.cpu = crqs_pkg::CPU_W'($urandom_range(eff_cpus() - 1));
		x.pid = crqs_pkg::PID_W'($urandom_range(255));
		x.pri = crqs_pkg::PRIO_W'($urandom_range(pri_max));
		return x;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// register write, only while the block is idle
	task automatic write_reg(input logic [crqs_pkg::CFG_IDX_W-1:0] idx,
			input logic [crqs_pkg::SLICE_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			crqs_pkg::REG_MODE:   sched_mode = data[crqs_pkg::MODE_W-1:0];
			crqs_pkg::REG_SLICE:  slice_len = data;
			crqs_pkg::REG_ACTIVE: act_cpus = data[crqs_pkg::ACT_W-1:0];
			default: ;
		endcase
	endtask

	// wait for every command to go out and every result to come back
	task automatic drain();
		while (cmd_backlog.size() != 0 || cmd_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [crqs_pkg::MODE_W-1:0] mode,
			input logic [crqs_pkg::SLICE_W-1:0] slice,
			input logic [crqs_pkg::ACT_W-1:0] act,
			input int count, input int wake_pct, input int pri_max);
		write_reg(crqs_pkg::REG_MODE, crqs_pkg::SLICE_W'(mode));
		write_reg(crqs_pkg::REG_SLICE, slice);
		write_reg(crqs_pkg::REG_ACTIVE, crqs_pkg::SLICE_W'(act));
		for (int k = 0; k < count; k++)
			cmd_backlog.push_back(rand_cmd(wake_pct, pri_max));
		drain();
	endtask

	// command driver: hold the item until taken, then maybe idle
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready)
				schedule_cmd({command, cpu, pid, priority_req});
			if (!cmd_valid || cmd_ready) begin
				if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					cmd_valid <= 1'b1;
					command <= cmd_backlog[0].cmd;
					cpu <= cmd_backlog[0].cpu;
					pid <= cmd_backlog[0].pid;
					priority_req <= cmd_backlog[0].pri;
					void'(cmd_backlog.pop_front());
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare with the oldest prediction, stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d cpu %0d pid %0d",
						kind, target_cpu, chosen_pid));
				end else begin
					want = due_results.pop_front();
					if (kind !== want.kind)
						report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
					if (target_cpu !== want.tcpu)
						report_mismatch($sformatf("target_cpu %0d, want %0d",
							target_cpu, want.tcpu));
					if (chosen_pid !== want.pid)
						report_mismatch($sformatf("chosen_pid %0d, want %0d",
							chosen_pid, want.pid));
					if (granted_slice !== want.slice)
						report_mismatch($sformatf("granted_slice %0d, want %0d",
							granted_slice, $signed(want.slice)));
				end
			end
			// long hold-off so the block backs up and stalls its input
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NCPU; i++)
			cpu_busy[i] = 1'b0;

		// reset values: FIFO, unlimited slice, one CPU
		add_cmd(crqs_pkg::CMD_RELEASE, 0, 0, 0);
		add_cmd(crqs_pkg::CMD_PREEMPT, 0, 0, 0);
		add_cmd(crqs_pkg::CMD_WAKE, 0, 0, 0);
		add_cmd(crqs_pkg::CMD_WAKE, 9, 255, 255);
		add_cmd(crqs_pkg::CMD_RELEASE, 0, 1, 1);
		add_cmd(crqs_pkg::CMD_PREEMPT, 0, 2, 2);
		add_cmd(crqs_pkg::CMD_IDLE, 15, 3, 3);
		add_cmd(crqs_pkg::CMD_IDLE, 0, 4, 4);
		add_cmd(crqs_pkg::CMD_RELEASE, 0, 5, 5);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// priority mode on two CPUs: ties, preempt requests, preemption
		write_reg(crqs_pkg::REG_MODE, crqs_pkg::SLICE_W'(crqs_pkg::MODE_PRIO));
		write_reg(crqs_pkg::REG_SLICE, 17'd0);
		write_reg(crqs_pkg::REG_ACTIVE, 17'd2);
		add_cmd(crqs_pkg::CMD_WAKE, 0, 10, 5);
		add_cmd(crqs_pkg::CMD_WAKE, 0, 11, 9);
		add_cmd(crqs_pkg::CMD_WAKE, 0, 12, 9);
		add_cmd(crqs_pkg::CMD_RELEASE, 0, 0, 0);
		add_cmd(crqs_pkg::CMD_RELEASE, 1, 0, 0);
		add_cmd(crqs_pkg::CMD_WAKE, 0, 13, 9);
		add_cmd(crqs_pkg::CMD_WAKE, 0, 14, 200);
		add_cmd(crqs_pkg::CMD_PREEMPT, 0, 0, 0);
		add_cmd(crqs_pkg::CMD_WAKE, 0, 15, 250);
		add_cmd(crqs_pkg::CMD_PREEMPT, 1, 0, 0);
		add_cmd(crqs_pkg::CMD_PREEMPT, 3, 0, 0);
		add_cmd(crqs_pkg::CMD_IDLE, 1, 0, 0);
		drain();

		// random phases; the first runs with no idling on either side
		calm <= 1'b1;
		run_phase(MODE_RR, 17'd65535, 5'd16, 120, 50, 255);
		calm <= 1'b0;
		hold_req <= 1'b1;
		run_phase(crqs_pkg::MODE_PRIO, SLICE_UNLIMITED, 5'd4, 150, 75, 255);
		run_phase(MODE_SPARE, 17'd0, 5'd0, 100, 50, 255);
		run_phase(crqs_pkg::MODE_PRIO, crqs_pkg::SLICE_W'($urandom_range(17'h1FFFF)),
			5'd31, 150, 65, 3);
		run_phase(MODE_FIFO, crqs_pkg::SLICE_W'($urandom_range(17'h1FFFF)),
			crqs_pkg::ACT_W'($urandom_range(1, 16)), 100, 40, 255);
		run_phase(crqs_pkg::MODE_PRIO, crqs_pkg::SLICE_W'($urandom_range(17'h1FFFF)),
			crqs_pkg::ACT_W'($urandom_range(1, 16)), 130, 55, 255);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
